@@ hw/rtl/slt_pkg.sv @@
// Package for the sorted label table: operation and status codes, FSM states,
// shared sizes and the command/status structs. No dependencies.
package slt_pkg;

   localparam int TableDepthDefault = 16;
   localparam int LabelBitsDefault  = 16;
   localparam int DataBitsDefault   = 32;

   localparam logic [2:0] OP_INSERT    = 3'd0;
   localparam logic [2:0] OP_DEL_LABEL = 3'd1;
   localparam logic [2:0] OP_DEL_DATA  = 3'd2;
   localparam logic [2:0] OP_LOOKUP    = 3'd3;
   localparam logic [2:0] OP_MEMBER    = 3'd4;
   localparam logic [2:0] OP_CLEAR     = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load;  // capture request
      logic exec;  // search and update the table
   } cmd_type;

   typedef struct packed {
      logic done;  // result has been computed
   } stat_type;

endpackage

@@ hw/rtl/slt_ctrl.sv @@
// Controller state machine for the sorted label table.
// Depends on slt_pkg.
module slt_ctrl import slt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd,
   input  stat_type stat
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

@@ hw/rtl/slt_path.sv @@
// Datapath for the sorted label table: a row of entry cells with parallel
// compare, shift on insert/delete, and the result register. Depends on slt_pkg.
module slt_path import slt_pkg::*; #(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int LABEL_BITS  = LabelBitsDefault,
   parameter int DATA_BITS   = DataBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output stat_type                      stat,
   input  logic [2:0]                    req_op,
   input  logic signed [LABEL_BITS-1:0]  req_key_label,
   input  logic [DATA_BITS-1:0]          req_entry_data,
   output logic [1:0]                    rsp_status,
   output logic [DATA_BITS-1:0]          rsp_found_data,
   output logic [$clog2(TABLE_DEPTH+1)-1:0] rsp_entry_count
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [2:0]                   op_ff;
   logic signed [LABEL_BITS-1:0] lab_ff;
   logic [DATA_BITS-1:0]         dat_ff;

   logic signed [LABEL_BITS-1:0] label_ff [TABLE_DEPTH];
   logic [DATA_BITS-1:0]         data_ff  [TABLE_DEPTH];
   logic [CW-1:0]                count_ff, count_in;

   // per-cell flags
   logic [TABLE_DEPTH-1:0] valid, lt, eq, deq;
   logic [TABLE_DEPTH-1:0] ins_after, ins_here, lab_first;
   logic [TABLE_DEPTH-1:0] lab_after, dat_after;
   logic lab_hit, dat_hit;
   logic [DATA_BITS-1:0] hit_data;
   logic [1:0] status_in;
   logic [DATA_BITS-1:0] found_in;
   logic do_ins, do_del, del_lab;

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         valid[i] = (CW'(i) < count_ff);
         lt[i]    = valid[i] && (label_ff[i] < lab_ff);
         eq[i]    = valid[i] && (label_ff[i] == lab_ff);
         deq[i]   = valid[i] && (data_ff[i] == dat_ff);
      end
   end

   // sorted order: first label match is an eq cell with all earlier cells lt
   always_comb begin
      lab_first[0] = eq[0];
      lab_after[0] = eq[0];
      dat_after[0] = deq[0];
      ins_here[0]  = ~lt[0];
      for (int i = 1; i < TABLE_DEPTH; i++) begin
         lab_first[i] = eq[i] && lt[i-1];
         // cells at or past the removed one
         lab_after[i] = lab_after[i-1] | lab_first[i];
         dat_after[i] = dat_after[i-1] | deq[i];
         // the new entry lands in the first cell that is not below it
         ins_here[i]  = ~lt[i] && lt[i-1];
      end
      ins_after = ~lt;
      lab_hit = |lab_first;
      dat_hit = |deq;
      hit_data = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (lab_first[i]) hit_data = hit_data | data_ff[i];
      end
   end

   always_comb begin
      status_in = ST_OK;
      found_in  = '0;
      count_in  = count_ff;
      do_ins    = 1'b0;
      do_del    = 1'b0;
      del_lab   = 1'b0;
      case (op_ff)
         OP_INSERT: begin
            if (count_ff == CW'(TABLE_DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               do_ins   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         OP_DEL_LABEL: begin
            if (lab_hit) begin
               do_del = 1'b1; del_lab = 1'b1; count_in = count_ff - 1'b1;
            end else begin
               status_in = ST_MISS;
            end
         end
         OP_DEL_DATA: begin
            if (dat_hit) begin
               do_del = 1'b1; count_in = count_ff - 1'b1;
            end else begin
               status_in = ST_MISS;
            end
         end
         OP_LOOKUP: begin
            if (lab_hit) found_in = hit_data;
            else         status_in = ST_MISS;
         end
         OP_MEMBER: begin
            if (!dat_hit) status_in = ST_MISS;
         end
         OP_CLEAR: count_in = '0;
         default: ;
      endcase
   end

   assign stat.done = cmd.exec;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         lab_ff <= req_key_label;
         dat_ff <= req_entry_data;
      end
      if (cmd.exec) begin
         rsp_status     <= status_in;
         rsp_found_data <= found_in;
         if (do_ins) begin
            if (ins_here[0]) begin
               label_ff[0] <= lab_ff;
               data_ff[0]  <= dat_ff;
            end
            for (int i = 1; i < TABLE_DEPTH; i++) begin
               if (ins_here[i]) begin
                  label_ff[i] <= lab_ff;
                  data_ff[i]  <= dat_ff;
               end else if (ins_after[i]) begin
                  label_ff[i] <= label_ff[i-1];
                  data_ff[i]  <= data_ff[i-1];
               end
            end
         end else if (do_del) begin
            for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
               if (del_lab ? lab_after[i] : dat_after[i]) begin
                  label_ff[i] <= label_ff[i+1];
                  data_ff[i]  <= data_ff[i+1];
               end
            end
         end
      end
   end

   assign rsp_entry_count = count_ff;

endmodule

@@ hw/rtl/sorted_label_table_top.sv @@
// Top level of the sorted label table: controller plus cell-row datapath.
// Depends on slt_pkg, slt_ctrl, slt_path.
//
// Sorted label table: holds up to TABLE_DEPTH (label, data) entries in
// ascending signed label order, new entries going ahead of equal labels.
// Each request passes through capture, then an execute step in which every
// cell compares against the request in parallel and the row shifts for an
// insert or delete, then a respond state holding the response until taken.
// The next request is accepted after the response leaves, as the controller's
// capture/execute/respond sequence sets. Entry contents are not reset; only
// the entry count is, so no clearing pass is needed.
module sorted_label_table_top import slt_pkg::*; #(
   parameter int TABLE_DEPTH = TableDepthDefault,
   parameter int LABEL_BITS  = LabelBitsDefault,
   parameter int DATA_BITS   = DataBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_op,
   input  logic signed [LABEL_BITS-1:0]  req_key_label,
   input  logic [DATA_BITS-1:0]          req_entry_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [DATA_BITS-1:0]          rsp_found_data,
   output logic [$clog2(TABLE_DEPTH+1)-1:0] rsp_entry_count
);

   cmd_type  cmd;
   stat_type stat;

   // sequence each request through capture, execute and respond
   slt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // hold the entries and compute the response
   slt_path #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .LABEL_BITS  (LABEL_BITS),
      .DATA_BITS   (DATA_BITS)
   ) u_path (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_op          (req_op),
      .req_key_label   (req_key_label),
      .req_entry_data  (req_entry_data),
      .rsp_status      (rsp_status),
      .rsp_found_data  (rsp_found_data),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

@@ dv/testbench.sv @@
// Testbench for the sorted label table: random and directed requests against
// an in-bench predictor of the sorted entry list. Depends on slt_pkg and
// sorted_label_table_top.
module testbench import slt_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH  = 16;
   localparam int NITEMS = 600;
   localparam int WATCHDOG_LIMIT = 20000;

   // One expected response of the table.
   typedef struct {
      logic [1:0]  status;
      logic [31:0] found;
      logic [4:0]  count;
   } table_answer_type;

   // Scoreboard: holds its own copy of the table and the pending answers.
   class table_scoreboard;
      logic signed [15:0] labels[$];
      logic [31:0]        datas[$];
      table_answer_type   pending[$];
      int                 errors;

      function void note_request(logic [2:0] op, logic signed [15:0] lab,
                                 logic [31:0] dat);
         table_answer_type a;
         int pos;
         a.status = ST_OK;
         a.found  = '0;
         pos = 0;
         case (op)
            OP_INSERT: begin
               if (labels.size() >= DEPTH) a.status = ST_FULL;
               else begin
                  while (pos < labels.size() && labels[pos] < lab) pos++;
                  labels.insert(pos, lab);
                  datas.insert(pos, dat);
               end
            end
            OP_DEL_LABEL, OP_LOOKUP: begin
               while (pos < labels.size() && labels[pos] < lab) pos++;
               if (pos < labels.size() && labels[pos] == lab) begin
                  if (op == OP_LOOKUP) a.found = datas[pos];
                  else begin
                     labels.delete(pos);
                     datas.delete(pos);
                  end
               end else a.status = ST_MISS;
            end
            OP_DEL_DATA, OP_MEMBER: begin
               while (pos < datas.size() && datas[pos] != dat) pos++;
               if (pos < datas.size()) begin
                  if (op == OP_DEL_DATA) begin
                     labels.delete(pos);
                     datas.delete(pos);
                  end
               end else a.status = ST_MISS;
            end
            OP_CLEAR: begin
               labels.delete();
               datas.delete();
            end
            default: ;  // unused codes leave the table alone
         endcase
         a.count = 5'(labels.size());
         pending.push_back(a);
      endfunction

      task automatic report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
         errors++;
      endtask

      task automatic check_response(logic [1:0] st, logic [31:0] fd, logic [4:0] cnt);
         table_answer_type a;
         if (pending.size() == 0) begin
            report("unexpected response", 32'(st), 32'd0);
            return;
         end
         a = pending.pop_front();
         if (st !== a.status) report("status", 32'(st), 32'(a.status));
         if (fd !== a.found) report("found_data", fd, a.found);
         if (cnt !== a.count) report("entry_count", 32'(cnt), 32'(a.count));
      endtask
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic [2:0] req_op;
   logic signed [15:0] req_key_label;
   logic [31:0] req_entry_data, rsp_found_data;
   logic [1:0] rsp_status;
   logic [4:0] rsp_entry_count;

   table_scoreboard sb = new();
   int  idle_cycles;
   bit  sender_done;
   bit  hold_rsp;       // long receiver hold-off requested by the sender
   logic signed [15:0] used_labels[$];
   logic [31:0]        used_datas[$];

   sorted_label_table_top i_dut (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Pick a gap length: mostly none or short, sometimes long.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Present one request and hold it until the table takes it.
   task automatic send_request(logic [2:0] op, logic signed [15:0] lab, logic [31:0] dat);
      req_valid      <= 1'b1;
      req_op         <= op;
      req_key_label  <= lab;
      req_entry_data <= dat;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, lab, dat);
      used_labels.push_back(lab);
      used_datas.push_back(dat);
      if (used_labels.size() > 24) begin
         void'(used_labels.pop_front());
         void'(used_datas.pop_front());
      end
   endtask

   // Drop valid for a random gap (zero means keep streaming).
   task automatic idle_gap();
      int n;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_gapped(logic [2:0] op, logic signed [15:0] lab, logic [31:0] dat);
      send_request(op, lab, dat);
      idle_gap();
   endtask

   // Labels from a narrow pool, so duplicates, hits and misses all occur.
   function automatic logic signed [15:0] rand_label();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4 && used_labels.size() > 0)
         return used_labels[$urandom_range(0, used_labels.size() - 1)];
      if (r < 7) return 16'($signed($urandom_range(0, 15)) - 8);
      return 16'($urandom());
   endfunction

   function automatic logic [31:0] rand_data();
      if ($urandom_range(0, 1) && used_datas.size() > 0)
         return used_datas[$urandom_range(0, used_datas.size() - 1)];
      return $urandom();
   endfunction

   // Stimulus.
   initial begin
      int r;
      logic [2:0] op;
      req_valid = 0;
      req_op = OP_INSERT;
      req_key_label = '0;
      req_entry_data = '0;
      hold_rsp = 0;
      sender_done = 0;
      reset = 1;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: lookups, deletes and a member check on an empty table, label extremes,
      // equal labels (new goes ahead), fill to full and a rejected insert, unused codes.
      send_gapped(OP_LOOKUP, 16'sh7fff, 32'h0);
      send_gapped(OP_DEL_LABEL, 16'sh8000, 32'h0);
      send_gapped(OP_DEL_DATA, 16'sh0000, 32'hffff_ffff);
      send_gapped(OP_MEMBER, 16'sh0000, 32'h0);
      send_gapped(OP_INSERT, 16'sh7fff, 32'hffff_ffff);
      send_gapped(OP_INSERT, 16'sh8000, 32'h0000_0000);
      send_gapped(OP_INSERT, 16'sh0005, 32'haaaa_5555);
      send_gapped(OP_INSERT, 16'sh0005, 32'h5555_aaaa);
      send_gapped(OP_LOOKUP, 16'sh0005, 32'h0);
      send_gapped(OP_MEMBER, 16'sh0000, 32'hffff_ffff);
      send_gapped(OP_DEL_DATA, 16'sh0000, 32'haaaa_5555);
      send_gapped(OP_DEL_LABEL, 16'sh7fff, 32'h0);
      send_gapped(3'd6, 16'sh1234, 32'h1);
      send_gapped(3'd7, 16'shffff, 32'h2);
      // two entries are left; fill the other fourteen cells
      for (int i = 0; i < 14; i++)
         send_request(OP_INSERT, 16'($urandom_range(0, 3)), $urandom());
      send_gapped(OP_INSERT, 16'sh0000, 32'h1);   // table full, rejected
      send_gapped(OP_LOOKUP, 16'sh8000, 32'h0);
      send_gapped(OP_CLEAR, 16'sh0000, 32'h0);

      // Random part: phases biased to filling or draining the table.
      for (int i = 0; i < NITEMS; i++) begin
         if (i == 200) hold_rsp = 1;    // receiver holds off, sender keeps going
         if (i == 400) begin
            // pause until every expected response has come
            req_valid <= 1'b0;
            while (sb.pending.size() != 0) @(posedge clock);
         end
         r = $urandom_range(0, 99);
         if ((i / 60) % 2 == 0)
            op = (r < 45) ? OP_INSERT : (r < 60) ? OP_LOOKUP : (r < 70) ? OP_MEMBER :
                 (r < 82) ? OP_DEL_LABEL : (r < 94) ? OP_DEL_DATA : (r < 97) ? 3'(r & 7) :
                 OP_CLEAR;
         else
            op = (r < 20) ? OP_INSERT : (r < 35) ? OP_LOOKUP : (r < 45) ? OP_MEMBER :
                 (r < 70) ? OP_DEL_LABEL : (r < 95) ? OP_DEL_DATA : (r < 98) ? 3'd6 :
                 OP_CLEAR;
         if ($urandom_range(0, 3) == 0) send_request(op, rand_label(), rand_data());
         else send_gapped(op, rand_label(), rand_data());
      end
      req_valid <= 1'b0;
      sender_done = 1;
   end

   // Receiver: random stall, plus one long hold-off counted here.
   initial begin
      int n;
      rsp_stall = 1;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 0;
            rsp_stall <= 1'b1;
            repeat (60) @(posedge clock);
         end
         n = gap_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Check responses and keep the watchdog.
   always @(posedge clock) begin
      if (reset) idle_cycles <= 0;
      else begin
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_status, rsp_found_data, rsp_entry_count);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // End of run.
   initial begin
      @(negedge reset);
      while (!(sender_done && sb.pending.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         repeat (20) @(posedge clock);
         if (sb.errors == 0 && sb.pending.size() == 0) $display("testbench OK");
         else $display("testbench NOT OK");
         $finish;
      end
   end

endmodule

@@ sim.f @@
hw/rtl/slt_pkg.sv
hw/rtl/slt_ctrl.sv
hw/rtl/slt_path.sv
hw/rtl/sorted_label_table_top.sv
dv/testbench.sv
